@@ hw/rtl/rmts_pkg.sv @@
// Package for the rate monotonic task scheduler: widths, mode and status codes,
// controller states and the command and status bundles. Depends on nothing.
package rmts_pkg;

  localparam int unsigned DefMaxTasks = 16;
  localparam int unsigned IdW = 22;
  localparam int unsigned PerW = 16;
  localparam int unsigned UtilW = 14;
  localparam int unsigned TimeW = 32;
  localparam int unsigned AgeW = 16;
  localparam int unsigned QuotW = 30;
  localparam logic [UtilW-1:0] UtilLimitReset = 14'd6930;
  localparam logic [13:0] UtilScale = 14'd10000;

  typedef enum logic [1:0] {
    MODE_REG = 2'd0,
    MODE_YIELD = 2'd1,
    MODE_DEREG = 2'd2,
    MODE_TICK = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_OVER = 2'd1,
    ST_BAD = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RS_READY = 2'd0,
    RS_SLEEP = 2'd1,
    RS_RUN = 2'd2
  } run_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_ADMIT,
    S_YIELD,
    S_DEREG,
    S_TICK,
    S_DISP,
    S_PICK,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_step;
    logic div_start;
    logic div_step;
    logic do_admit;
    logic do_yield;
    logic do_dereg;
    logic do_tick;
    logic disp_clear;
    logic disp_step;
    logic do_pick;
    logic set_status;
    status_t status;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic scan_last;
    logic div_last;
    logic bad_reg;
    logic found;
    logic over;
    logic any_rel;
  } sts_t;

endpackage

@@ hw/rtl/rmts_ctrl.sv @@
// Controller state machine for the rate monotonic task scheduler.
// Depends on rmts_pkg.
module rmts_ctrl import rmts_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.status = ST_DONE;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          unique case (sts.mode)
            MODE_REG: begin
              if (sts.bad_reg) begin
                cmd.set_status = 1'b1;
                cmd.status = ST_BAD;
                state_nxt = S_OUT;
              end else begin
                cmd.div_start = 1'b1;
                state_nxt = S_DIV;
              end
            end
            MODE_YIELD: state_nxt = S_YIELD;
            MODE_DEREG: state_nxt = S_DEREG;
            MODE_TICK: state_nxt = S_TICK;
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_ADMIT;
        end
      end
      S_ADMIT: begin
        cmd.set_status = 1'b1;
        if (sts.over) begin
          cmd.status = ST_OVER;
        end else begin
          cmd.do_admit = 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_YIELD: begin
        cmd.set_status = 1'b1;
        if (sts.found) begin
          cmd.do_yield = 1'b1;
          cmd.scan_start = 1'b1;
          cmd.disp_clear = 1'b1;
          state_nxt = S_DISP;
        end else begin
          cmd.status = ST_UNKNOWN;
          state_nxt = S_OUT;
        end
      end
      S_DEREG: begin
        cmd.set_status = 1'b1;
        if (sts.found) begin
          cmd.do_dereg = 1'b1;
        end else begin
          cmd.status = ST_UNKNOWN;
        end
        state_nxt = S_OUT;
      end
      S_TICK: begin
        cmd.set_status = 1'b1;
        cmd.do_tick = 1'b1;
        if (sts.any_rel) begin
          cmd.scan_start = 1'b1;
          cmd.disp_clear = 1'b1;
          state_nxt = S_DISP;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DISP: begin
        cmd.disp_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        cmd.do_pick = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/rmts_dp.sv @@
// Datapath of the rate monotonic task scheduler: task table, slot scan,
// restoring divider, release check and dispatch search. Depends on rmts_pkg.
module rmts_dp import rmts_pkg::*; #(
  parameter int unsigned MAX_TASKS = DefMaxTasks
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [UtilW-1:0] cfg_wr_data,
  input  logic [1:0]       in_mode,
  input  logic [IdW-1:0]   in_task_id,
  input  logic [PerW-1:0]  in_period_ms,
  input  logic [PerW-1:0]  in_compute_ms,
  input  cmd_t             cmd,
  output sts_t             sts,
  output logic [1:0]       out_status,
  output logic             out_running_valid,
  output logic [IdW-1:0]   out_running_id,
  output logic             out_switched,
  output logic [UtilW-1:0] out_utilization_total
);

  localparam int unsigned SlotW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CntW = $clog2(MAX_TASKS + 1);
  localparam logic [CntW-1:0] LastSlot = CntW'(MAX_TASKS - 1);
  localparam int unsigned DivW = QuotW;

  logic [UtilW-1:0] limit_r;
  logic [MAX_TASKS-1:0] valid_r, armed_r;
  logic [IdW-1:0] id_r [MAX_TASKS];
  logic [PerW-1:0] per_r [MAX_TASKS];
  logic [UtilW-1:0] util_r [MAX_TASKS];
  run_state_t rs_r [MAX_TASKS];
  logic [TimeW-1:0] rel_r [MAX_TASKS];
  logic [AgeW-1:0] age_r [MAX_TASKS];
  logic [TimeW-1:0] now_r;
  logic run_valid_r;
  logic [SlotW-1:0] run_slot_r;
  logic [UtilW-1:0] sum_r;
  logic [AgeW-1:0] regcnt_r;

  mode_t mode_r;
  logic [IdW-1:0] id_in_r;
  logic [PerW-1:0] per_in_r, comp_in_r;
  logic [CntW-1:0] idx_r;
  logic found_r, free_found_r;
  logic [SlotW-1:0] hit_r, free_r;
  logic [DivW-1:0] num_r;
  logic [PerW:0] rem_r;
  logic [4:0] dcnt_r;
  logic best_v_r;
  logic [SlotW-1:0] best_r;
  logic [AgeW-1:0] best_dist_r;
  logic [1:0] status_r;
  logic switched_r;

  logic [SlotW-1:0] idx_s;
  logic [MAX_TASKS-1:0] rel_hit;
  logic [PerW:0] rem_sh;
  logic [UtilW+1:0] total;
  logic [AgeW-1:0] tie_gap;
  logic better;

  assign idx_s = idx_r[SlotW-1:0];
  assign rem_sh = {rem_r[PerW-1:0], num_r[DivW-1]};
  assign total = {2'b00, sum_r} + {2'b00, num_r[UtilW-1:0]};
  assign tie_gap = regcnt_r - age_r[idx_s];
  assign better = !best_v_r || (per_r[idx_s] < per_r[best_r]) ||
                  ((per_r[idx_s] == per_r[best_r]) && (tie_gap < best_dist_r));

  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      rel_hit[i] = valid_r[i] && armed_r[i] && (rel_r[i] == now_r + 32'd1);
    end
  end

  always_comb begin
    sts.mode = mode_r;
    sts.scan_last = (idx_r == LastSlot);
    sts.div_last = (dcnt_r == 5'd0);
    sts.bad_reg = (per_in_r == '0) || found_r ||
                  (!free_found_r && valid_r[idx_s] && !found_r &&
                   !(valid_r[idx_s] && id_r[idx_s] == id_in_r)) ||
                  (valid_r[idx_s] && id_r[idx_s] == id_in_r);
    if (!free_found_r && !valid_r[idx_s]) begin
      sts.bad_reg = (per_in_r == '0) || found_r;
    end
    sts.found = found_r;
    sts.over = (num_r[DivW-1:UtilW] != '0) || (total > {2'b00, limit_r});
    sts.any_rel = |rel_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= UtilLimitReset;
      valid_r <= '0;
      armed_r <= '0;
      now_r <= '0;
      run_valid_r <= 1'b0;
      run_slot_r <= '0;
      sum_r <= '0;
      regcnt_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (cmd.do_admit) begin
        valid_r[free_r] <= 1'b1;
        armed_r[free_r] <= 1'b0;
        regcnt_r <= regcnt_r + 1'b1;
        sum_r <= total[UtilW-1:0];
      end
      if (cmd.do_yield) begin
        if (!armed_r[hit_r]) begin
          armed_r[hit_r] <= 1'b1;
        end
        if (run_valid_r && run_slot_r == hit_r) begin
          run_valid_r <= 1'b0;
        end
      end
      if (cmd.do_dereg) begin
        valid_r[hit_r] <= 1'b0;
        armed_r[hit_r] <= 1'b0;
        sum_r <= sum_r - util_r[hit_r];
        if (run_valid_r && run_slot_r == hit_r) begin
          run_valid_r <= 1'b0;
        end
      end
      if (cmd.do_tick) begin
        now_r <= now_r + 32'd1;
      end
      if (cmd.do_pick && best_v_r) begin
        if (!run_valid_r || per_r[best_r] < per_r[run_slot_r]) begin
          run_valid_r <= 1'b1;
          run_slot_r <= best_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode_t'(in_mode);
      id_in_r <= in_task_id;
      per_in_r <= in_period_ms;
      comp_in_r <= in_compute_ms;
    end
    if (cmd.scan_start) begin
      idx_r <= '0;
    end else if (cmd.scan_step || cmd.disp_step) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.load) begin
      found_r <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.scan_step) begin
      if (valid_r[idx_s] && id_r[idx_s] == id_in_r) begin
        found_r <= 1'b1;
        hit_r <= idx_s;
      end
      if (!valid_r[idx_s] && !free_found_r) begin
        free_found_r <= 1'b1;
        free_r <= idx_s;
      end
    end
    if (cmd.div_start) begin
      num_r <= DivW'(comp_in_r) * DivW'(UtilScale);
      rem_r <= '0;
      dcnt_r <= 5'(DivW - 1);
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, per_in_r}) begin
        rem_r <= rem_sh - {1'b0, per_in_r};
        num_r <= {num_r[DivW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        num_r <= {num_r[DivW-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r - 5'd1;
    end
    if (cmd.load) begin
      switched_r <= 1'b0;
      status_r <= ST_DONE;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
    if (cmd.disp_clear) begin
      best_v_r <= 1'b0;
      best_dist_r <= '0;
    end else if (cmd.disp_step) begin
      if (valid_r[idx_s] && rs_r[idx_s] == RS_READY && better) begin
        best_v_r <= 1'b1;
        best_r <= idx_s;
        best_dist_r <= tie_gap;
      end
    end
    if (cmd.do_pick && best_v_r) begin
      if (!run_valid_r) begin
        rs_r[best_r] <= RS_RUN;
        switched_r <= 1'b1;
      end else if (per_r[best_r] < per_r[run_slot_r]) begin
        rs_r[run_slot_r] <= RS_READY;
        rs_r[best_r] <= RS_RUN;
        switched_r <= 1'b1;
      end
    end
    if (cmd.do_admit) begin
      id_r[free_r] <= id_in_r;
      per_r[free_r] <= per_in_r;
      util_r[free_r] <= num_r[UtilW-1:0];
      rs_r[free_r] <= RS_SLEEP;
      age_r[free_r] <= regcnt_r + 1'b1;
    end
    if (cmd.do_yield) begin
      rs_r[hit_r] <= RS_SLEEP;
      if (!armed_r[hit_r]) begin
        rel_r[hit_r] <= now_r + {{(TimeW - PerW) {1'b0}}, per_r[hit_r]};
      end
    end
    if (cmd.do_tick) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        if (rel_hit[i]) begin
          rs_r[i] <= RS_READY;
          rel_r[i] <= rel_r[i] + {{(TimeW - PerW) {1'b0}}, per_r[i]};
        end
      end
    end
  end

  assign out_status = status_r;
  assign out_running_valid = run_valid_r;
  assign out_running_id = run_valid_r ? id_r[run_slot_r] : '0;
  assign out_switched = switched_r;
  assign out_utilization_total = sum_r;

endmodule

@@ hw/rtl/rate_monotonic_task_scheduler_core.sv @@
// Top level of the rate monotonic task scheduler.
// Depends on rmts_pkg, rmts_ctrl and rmts_dp.
//
// One input word carries a mode (register, yield, deregister, tick), a task
// id, a period and a computation time. For every word accepted the block
// returns one result word: status, running task, switch flag and summed
// utilization. Both channels use valid and ready.
// An item is accepted, then the table is scanned; then the bit-serial
// divider runs for a registration, or a second dispatch scan follows a
// yield or a releasing tick. Both scans use the single shared scan counter.
// Items are worked one at a time; the next is taken once the result is read.
// The result holds while out_ready is low and no input is taken meanwhile.
// Reset clears the table, the time, the running task and the sum, and sets
// the utilization limit to 6930. cfg_wr_en writes the limit; the user must
// assert it only while idle, as the block itself does not enforce this.
module rate_monotonic_task_scheduler_core import rmts_pkg::*; #(
  parameter int unsigned MAX_TASKS = DefMaxTasks
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [UtilW-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_mode,
  input  logic [IdW-1:0]   in_task_id,
  input  logic [PerW-1:0]  in_period_ms,
  input  logic [PerW-1:0]  in_compute_ms,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_status,
  output logic             out_running_valid,
  output logic [IdW-1:0]   out_running_id,
  output logic             out_switched,
  output logic [UtilW-1:0] out_utilization_total
);

  cmd_t cmd;
  sts_t sts;

  rmts_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  rmts_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_mode(in_mode), .in_task_id(in_task_id), .in_period_ms(in_period_ms),
    .in_compute_ms(in_compute_ms), .cmd(cmd), .sts(sts),
    .out_status(out_status), .out_running_valid(out_running_valid),
    .out_running_id(out_running_id), .out_switched(out_switched),
    .out_utilization_total(out_utilization_total)
  );

endmodule

@@ tb/rmts_checker.sv @@
// Checker for the rate monotonic task scheduler: watches the input, result and
// configuration ports, predicts every result word and compares it.
// Depends on rmts_pkg.
`timescale 1ns / 1ps
module rmts_checker import rmts_pkg::*; #(
  parameter int unsigned MAX_TASKS = DefMaxTasks
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [UtilW-1:0] cfg_wr_data,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [1:0]       in_mode,
  input  logic [IdW-1:0]   in_task_id,
  input  logic [PerW-1:0]  in_period_ms,
  input  logic [PerW-1:0]  in_compute_ms,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [1:0]       out_status,
  input  logic             out_running_valid,
  input  logic [IdW-1:0]   out_running_id,
  input  logic             out_switched,
  input  logic [UtilW-1:0] out_utilization_total,
  output int               errors,
  output int               pending
);

  typedef struct {
    status_t          status;
    logic             run_valid;
    logic [IdW-1:0]   run_id;
    logic             switched;
    logic [UtilW-1:0] util;
  } sched_word_t;

  sched_word_t      expected_words[$];
  logic [UtilW-1:0] util_limit;
  logic             tk_valid[MAX_TASKS];
  logic [IdW-1:0]   tk_id[MAX_TASKS];
  logic [PerW-1:0]  tk_period[MAX_TASKS];
  logic [UtilW-1:0] tk_util[MAX_TASKS];
  run_state_t       tk_state[MAX_TASKS];
  logic [TimeW-1:0] tk_release[MAX_TASKS];
  logic             tk_armed[MAX_TASKS];
  logic [AgeW-1:0]  tk_age[MAX_TASKS];
  logic [TimeW-1:0] now_ms;
  logic             run_valid;
  int               run_slot;
  logic [UtilW-1:0] util_sum;
  logic [AgeW-1:0]  reg_count;

  function automatic int find_task(logic [IdW-1:0] id);
    for (int i = 0; i < MAX_TASKS; i++)
      if (tk_valid[i] && tk_id[i] == id) return i;
    return -1;
  endfunction

  task automatic pick_task(output logic sw);
    int best;
    logic [AgeW-1:0] best_dist, tie_gap;
    best = -1;
    best_dist = '0;
    sw = 1'b0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (tk_valid[i] && tk_state[i] == RS_READY) begin
        tie_gap = reg_count - tk_age[i];
        if (best < 0 || tk_period[i] < tk_period[best] ||
            (tk_period[i] == tk_period[best] && tie_gap < best_dist)) begin
          best = i;
          best_dist = tie_gap;
        end
      end
    end
    if (best >= 0) begin
      if (run_valid) begin
        if (tk_period[best] < tk_period[run_slot]) begin
          tk_state[run_slot] = RS_READY;
          tk_state[best] = RS_RUN;
          run_slot = best;
          sw = 1'b1;
        end
      end else begin
        tk_state[best] = RS_RUN;
        run_slot = best;
        run_valid = 1'b1;
        sw = 1'b1;
      end
    end
  endtask

  task automatic predict_word(input logic [1:0] md, input logic [IdW-1:0] id,
                              input logic [PerW-1:0] per, input logic [PerW-1:0] comp);
    sched_word_t w;
    int s, free_slot;
    logic [63:0] u, total;
    logic any;
    w.status = ST_DONE;
    w.switched = 1'b0;
    case (mode_t'(md))
      MODE_REG: begin
        if (per == 0 || find_task(id) >= 0) begin
          w.status = ST_BAD;
        end else begin
          free_slot = -1;
          for (int i = MAX_TASKS - 1; i >= 0; i--)
            if (!tk_valid[i]) free_slot = i;
          if (free_slot < 0) begin
            w.status = ST_BAD;
          end else begin
            u = (64'(comp) * 64'd10000) / 64'(per);
            total = 64'(util_sum) + u;
            if (total > 64'(util_limit)) begin
              w.status = ST_OVER;
            end else begin
              tk_valid[free_slot] = 1'b1;
              tk_id[free_slot] = id;
              tk_period[free_slot] = per;
              tk_util[free_slot] = u[UtilW-1:0];
              tk_state[free_slot] = RS_SLEEP;
              tk_release[free_slot] = '0;
              tk_armed[free_slot] = 1'b0;
              reg_count = reg_count + 1'b1;
              tk_age[free_slot] = reg_count;
              util_sum = total[UtilW-1:0];
            end
          end
        end
      end
      MODE_YIELD: begin
        s = find_task(id);
        if (s < 0) begin
          w.status = ST_UNKNOWN;
        end else begin
          tk_state[s] = RS_SLEEP;
          if (!tk_armed[s]) begin
            tk_release[s] = now_ms + tk_period[s];
            tk_armed[s] = 1'b1;
          end
          if (run_valid && run_slot == s) run_valid = 1'b0;
          pick_task(w.switched);
        end
      end
      MODE_DEREG: begin
        s = find_task(id);
        if (s < 0) begin
          w.status = ST_UNKNOWN;
        end else begin
          tk_valid[s] = 1'b0;
          tk_armed[s] = 1'b0;
          util_sum = util_sum - tk_util[s];
          if (run_valid && run_slot == s) run_valid = 1'b0;
        end
      end
      default: begin
        any = 1'b0;
        now_ms = now_ms + 1'b1;
        for (int i = 0; i < MAX_TASKS; i++) begin
          if (tk_valid[i] && tk_armed[i] && tk_release[i] == now_ms) begin
            tk_state[i] = RS_READY;
            tk_release[i] = tk_release[i] + tk_period[i];
            any = 1'b1;
          end
        end
        if (any) pick_task(w.switched);
      end
    endcase
    w.run_valid = run_valid;
    w.run_id = run_valid ? tk_id[run_slot] : '0;
    w.util = util_sum;
    expected_words.push_back(w);
  endtask

  always @(posedge clk) begin
    sched_word_t w;
    if (!rst_n) begin
      util_limit = UtilLimitReset;
      for (int i = 0; i < MAX_TASKS; i++) begin
        tk_valid[i] = 1'b0;
        tk_armed[i] = 1'b0;
        tk_id[i] = '0;
        tk_period[i] = '0;
        tk_util[i] = '0;
        tk_state[i] = RS_READY;
        tk_release[i] = '0;
        tk_age[i] = '0;
      end
      now_ms = '0;
      run_valid = 1'b0;
      run_slot = 0;
      util_sum = '0;
      reg_count = '0;
      expected_words.delete();
      errors = 0;
    end else begin
      if (cfg_wr_en) util_limit = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result word with no expectation waiting", $time);
          errors++;
        end else begin
          w = expected_words.pop_front();
          if (out_status != w.status) begin
            $display("%0t: status expected %0d actual %0d", $time, w.status, out_status);
            errors++;
          end
          if (out_running_valid != w.run_valid) begin
            $display("%0t: running_valid expected %0b actual %0b", $time, w.run_valid,
                     out_running_valid);
            errors++;
          end
          if (out_running_id != w.run_id) begin
            $display("%0t: running_id expected %0d actual %0d", $time, w.run_id,
                     out_running_id);
            errors++;
          end
          if (out_switched != w.switched) begin
            $display("%0t: switched expected %0b actual %0b", $time, w.switched,
                     out_switched);
            errors++;
          end
          if (out_utilization_total != w.util) begin
            $display("%0t: utilization_total expected %0d actual %0d", $time, w.util,
                     out_utilization_total);
            errors++;
          end
        end
      end
      if (in_valid && in_ready)
        predict_word(in_mode, in_task_id, in_period_ms, in_compute_ms);
    end
    pending = expected_words.size();
  end

endmodule

@@ tb/tb_rate_monotonic_task_scheduler_core.sv @@
// Testbench top for the rate monotonic task scheduler: drives directed and
// random words with random gaps and stalls and gives the verdict.
// Depends on rmts_pkg, rmts_checker and rate_monotonic_task_scheduler_core.
`timescale 1ns / 1ps
module tb_rate_monotonic_task_scheduler_core;
  import rmts_pkg::*;

  localparam int WatchdogLimit = 5000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [UtilW-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       in_mode = MODE_TICK;
  logic [IdW-1:0]   in_task_id = '0;
  logic [PerW-1:0]  in_period_ms = '0;
  logic [PerW-1:0]  in_compute_ms = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       out_status;
  logic             out_running_valid;
  logic [IdW-1:0]   out_running_id;
  logic             out_switched;
  logic [UtilW-1:0] out_utilization_total;
  int               errors;
  int               pending;
  logic             no_gaps = 1'b0;
  int               idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rate_monotonic_task_scheduler_core u_dut (.*);

  rmts_checker u_checker (.*);

  task automatic send_word(input mode_t md, input logic [IdW-1:0] id,
                           input logic [PerW-1:0] per, input logic [PerW-1:0] comp);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_mode = md;
    in_task_id = id;
    in_period_ms = per;
    in_compute_ms = comp;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_limit(input logic [UtilW-1:0] value);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (60) @(posedge clk);
    @(negedge clk);
    cfg_wr_data = value;
    cfg_wr_en = 1'b1;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic random_word();
    int pick;
    logic [IdW-1:0] id;
    logic [PerW-1:0] per, comp;
    pick = $urandom_range(0, 99);
    id = ($urandom_range(0, 19) == 0) ? IdW'($urandom) : IdW'($urandom_range(1, 24));
    case ($urandom_range(0, 9))
      0: per = PerW'($urandom);
      1: per = '0;
      default: per = PerW'($urandom_range(1, 12));
    endcase
    comp = ($urandom_range(0, 9) == 0) ? PerW'($urandom) : PerW'($urandom_range(0, 3));
    if (pick < 40) send_word(MODE_TICK, IdW'($urandom), PerW'($urandom), PerW'($urandom));
    else if (pick < 65) send_word(MODE_YIELD, id, per, comp);
    else if (pick < 88) send_word(MODE_REG, id, per, comp);
    else send_word(MODE_DEREG, id, per, comp);
  endtask

  always begin
    int stall;
    stall = no_gaps ? 0 : $urandom_range(0, 17);
    out_ready = 1'b0;
    repeat (stall) @(negedge clk);
    out_ready = 1'b1;
    @(posedge clk);
    while (!out_valid) @(posedge clk);
    @(negedge clk);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [UtilW-1:0] limits[5];
    limits = '{UtilLimitReset, 14'd10000, 14'd0, UtilW'($urandom_range(0, 10000)), 14'd10000};
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    send_word(MODE_REG, 22'd5, 16'd0, 16'd1);
    send_word(MODE_REG, 22'h3FFFFF, 16'hFFFF, 16'hFFFF);
    send_word(MODE_REG, 22'd1, 16'd4, 16'd1);
    send_word(MODE_REG, 22'd1, 16'd4, 16'd1);
    send_word(MODE_YIELD, 22'd77, 16'd0, 16'd0);
    send_word(MODE_DEREG, 22'd77, 16'd0, 16'd0);
    send_word(MODE_YIELD, 22'd1, 16'd0, 16'd0);
    send_word(MODE_REG, 22'd2, 16'd2, 16'd0);
    send_word(MODE_YIELD, 22'd2, 16'd0, 16'd0);
    repeat (4) send_word(MODE_TICK, 22'h3FFFFF, 16'hFFFF, 16'hFFFF);
    send_word(MODE_DEREG, 22'd2, 16'd0, 16'd0);
    for (int i = 0; i < 15; i++) send_word(MODE_REG, IdW'(100 + i), 16'd1, 16'd0);
    send_word(MODE_REG, 22'd200, 16'd1, 16'd0);
    for (int i = 0; i < 15; i++) send_word(MODE_DEREG, IdW'(100 + i), 16'd0, 16'd0);
    send_word(MODE_DEREG, 22'd1, 16'd0, 16'd0);

    for (int ph = 0; ph < 5; ph++) begin
      write_limit(limits[ph]);
      for (int n = 0; n < 310; n++) begin
        if (n % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        random_word();
      end
      no_gaps = 1'b0;
    end

    in_valid = 1'b0;
    wait (pending == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
